FILE: src/rrrq_pkg.sv
package rrrq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_W = 8;
   localparam logic [ID_W-1:0] NO_ID = 8'hFF;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_SELECT = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type         command;
      logic [ID_W-1:0] process_id;
   } req_item_type;

   typedef struct packed {
      status_type      status;
      logic [ID_W-1:0] selected_id;
   } rsp_item_type;

endpackage

FILE: src/round_robin_ready_queue.sv
// Request to result: add and unknown commands, and select on an empty queue, go
// straight to the done state; select reads the head, and when the head rotates also
// copies it to the back and reads the new head; remove scans every entry.
// Requests: one at a time, taken once the previous result has left the engine.
// Reset: synchronous, clears head, count, selection and handshake; id store not swept.
module round_robin_ready_queue #(
   parameter int QUEUE_DEPTH = rrrq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [7:0] req_process_id,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_selected_id
);
   import rrrq_pkg::*;

   req_item_type eng_req;
   rsp_item_type eng_res;
   logic         eng_idle;
   logic         eng_res_valid;
   logic         eng_res_take;
   logic         start;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   assign req_stall = !eng_idle;
   assign start     = req_valid && eng_idle;

   assign eng_req.command    = cmd_type'(req_command);
   assign eng_req.process_id = req_process_id;

   rrrq_engine #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (eng_req),
      .idle      (eng_idle),
      .res_valid (eng_res_valid),
      .res_take  (eng_res_take),
      .res       (eng_res)
   );

   // output register frees up on a transfer
   assign eng_res_take = eng_res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (eng_res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = eng_res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = 2'(rsp_ff.status);
   assign rsp_selected_id = rsp_ff.selected_id;

endmodule

FILE: src/rrrq_engine.sv
module rrrq_engine #(
   parameter int QUEUE_DEPTH = rrrq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  rrrq_pkg::req_item_type req,
   output logic                  idle,
   output logic                  res_valid,
   input  logic                  res_take,
   output rrrq_pkg::rsp_item_type res
);
   import rrrq_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_REM,
      S_SEL_B,
      S_SEL_C,
      S_DONE
   } state_type;

   // head + offset, wrapped once; head stays below the depth, offset at most the depth
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [CW-1:0] offs);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(offs);
      if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CW+1)'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   state_type     state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic          cur_ff, cur_in;
   logic [CW-1:0] off_ff, off_in;
   logic          rv_ff, rv_in;
   logic          found_ff, found_in;
   logic          fhead_ff, fhead_in;
   logic [ID_W-1:0] pid_ff, pid_in;
   logic [AW-1:0] raddr_ff, raddr_in;
   logic [AW-1:0] dslot_ff, dslot_in;
   logic [AW-1:0] pslot_ff, pslot_in;
   rsp_item_type  res_ff, res_in;

   logic [ID_W-1:0] mem [QUEUE_DEPTH];
   logic [ID_W-1:0] rdata_ff;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [ID_W-1:0] wr_data;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      count_in = count_ff;
      cur_in   = cur_ff;
      off_in   = off_ff;
      rv_in    = rv_ff;
      found_in = found_ff;
      fhead_in = fhead_ff;
      pid_in   = pid_ff;
      raddr_in = raddr_ff;
      dslot_in = dslot_ff;
      pslot_in = pslot_ff;
      res_in   = res_ff;
      wr_en    = 1'b0;
      wr_addr  = slot_of(head_ff, count_ff);
      wr_data  = rdata_ff;
      rd_en    = 1'b0;
      rd_addr  = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               pid_in = req.process_id;
               res_in.selected_id = NO_ID;
               res_in.status      = ST_OK;
               case (req.command)
                  CMD_ADD: begin
                     state_in = S_DONE;
                     if (count_ff == CW'(QUEUE_DEPTH)) begin
                        res_in.status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_data  = req.process_id;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     state_in = S_REM;
                     off_in   = '0;
                     rv_in    = 1'b0;
                     found_in = 1'b0;
                     fhead_in = 1'b0;
                     raddr_in = head_ff;
                  end
                  CMD_SELECT: begin
                     if (count_ff == '0) begin
                        res_in.status = ST_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_SEL_B;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_REM: begin
            // data returned this cycle belongs to offset off_ff - 1
            if (rv_ff) begin
               pslot_in = dslot_ff;
               if (!found_ff) begin
                  if (rdata_ff == pid_ff) begin
                     found_in = 1'b1;
                     fhead_in = (off_ff == CW'(1));
                  end
               end else begin
                  // close the gap: move this entry one place towards the head
                  wr_en   = 1'b1;
                  wr_addr = pslot_ff;
                  wr_data = rdata_ff;
               end
            end
            if (off_ff < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = raddr_ff;
               rv_in    = 1'b1;
               dslot_in = raddr_ff;
               raddr_in = slot_of(raddr_ff, CW'(1));
               off_in   = off_ff + CW'(1);
            end else begin
               rv_in = 1'b0;
            end
            if (!rv_ff && (off_ff >= count_ff)) begin
               state_in = S_DONE;
               if (found_ff) begin
                  count_in = count_ff - CW'(1);
                  if (fhead_ff || (count_ff == CW'(1))) begin
                     cur_in = 1'b0;
                  end
                  res_in.status = ST_OK;
               end else begin
                  res_in.status = ST_NOT_FOUND;
               end
            end
         end

         S_SEL_B: begin
            if (cur_ff && (count_ff > CW'(1))) begin
               // rotate: old head copied to the back, head moves on
               wr_en    = 1'b1;
               wr_data  = rdata_ff;
               head_in  = slot_of(head_ff, CW'(1));
               rd_en    = 1'b1;
               rd_addr  = head_in;
               state_in = S_SEL_C;
            end else begin
               cur_in             = 1'b1;
               res_in.status      = ST_OK;
               res_in.selected_id = rdata_ff;
               state_in           = S_DONE;
            end
         end

         S_SEL_C: begin
            cur_in             = 1'b1;
            res_in.status      = ST_OK;
            res_in.selected_id = rdata_ff;
            state_in           = S_DONE;
         end

         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         cur_ff   <= 1'b0;
         off_ff   <= '0;
         rv_ff    <= 1'b0;
         found_ff <= 1'b0;
         fhead_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         cur_ff   <= cur_in;
         off_ff   <= off_in;
         rv_ff    <= rv_in;
         found_ff <= found_in;
         fhead_ff <= fhead_in;
      end
      pid_ff   <= pid_in;
      raddr_ff <= raddr_in;
      dslot_ff <= dslot_in;
      pslot_ff <= pslot_in;
      res_ff   <= res_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count beyond depth");

   a_cur_needs_entry: assert property (@(posedge clock) disable iff (reset)
      cur_ff |-> (count_ff != '0))
      else $error("selection held on an empty queue");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == S_IDLE))
      else $error("request started while busy");

   a_scan_offset: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_REM) && rv_ff) |-> (off_ff != '0))
      else $error("read data with no offset issued");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && !res_take) |=> ((state_ff == S_DONE) && $stable(res_ff)))
      else $error("result lost before transfer");
`endif

endmodule

FILE: tb/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rrrq_pkg::*;

   localparam int QUEUE_DEPTH    = QUEUE_DEPTH_DEF;
   localparam int RANDOM_PHASES  = 17;
   localparam int PHASE_ITEMS    = 100;
   localparam int WATCHDOG_LIMIT = 400;
   localparam int DRAIN_CYCLES   = 40;
   localparam int MAX_PRINTED    = 50;

   typedef enum int {
      PH_FILL,
      PH_CHURN,
      PH_DRAIN,
      PH_MIXED
   } phase_kind_type;

   typedef struct {
      cmd_type      cmd;
      logic [7:0]   pid;
      int           reps;
      bit           fixed;
      rsp_item_type rsp;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_command;
   logic [7:0] req_process_id;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_status;
   logic [7:0] rsp_selected_id;

   // scheduler image kept in step with the block
   logic [7:0] q_ids [QUEUE_DEPTH];
   logic [3:0] q_head;
   logic [4:0] q_count;
   bit         q_current;

   rsp_item_type pending_rsp [$];
   int         errors;
   int         idle_cycles;
   bit         no_gaps;
   int         n_cmd [4];
   int         n_status [4];

   stim_row_type directed_rows [24] = '{
      '{CMD_SELECT, 8'h00, 1,  1'b1, '{ST_EMPTY, NO_ID}},
      '{CMD_REMOVE, 8'h05, 1,  1'b1, '{ST_NOT_FOUND, NO_ID}},
      '{CMD_NONE,   8'hFF, 1,  1'b1, '{ST_OK, NO_ID}},
      '{CMD_ADD,    8'h07, 1,  1'b1, '{ST_OK, NO_ID}},
      '{CMD_SELECT, 8'h00, 1,  1'b0, '{ST_OK, NO_ID}},
      '{CMD_SELECT, 8'hFF, 1,  1'b0, '{ST_OK, NO_ID}},
      '{CMD_REMOVE, 8'h07, 1,  1'b1, '{ST_OK, NO_ID}},
      '{CMD_SELECT, 8'h00, 1,  1'b1, '{ST_EMPTY, NO_ID}},
      '{CMD_ADD,    8'h00, 1,  1'b1, '{ST_OK, NO_ID}},
      '{CMD_ADD,    8'hFF, 1,  1'b1, '{ST_OK, NO_ID}},
      '{CMD_ADD,    8'hAA, 1,  1'b1, '{ST_OK, NO_ID}},
      '{CMD_ADD,    8'h55, 1,  1'b1, '{ST_OK, NO_ID}},
      '{CMD_SELECT, 8'h00, 1,  1'b0, '{ST_OK, NO_ID}},
      '{CMD_SELECT, 8'h00, 1,  1'b0, '{ST_OK, NO_ID}},
      '{CMD_REMOVE, 8'hFF, 1,  1'b1, '{ST_OK, NO_ID}},
      '{CMD_SELECT, 8'h00, 1,  1'b0, '{ST_OK, NO_ID}},
      '{CMD_ADD,    8'hAA, 1,  1'b1, '{ST_OK, NO_ID}},
      '{CMD_REMOVE, 8'hAA, 1,  1'b1, '{ST_OK, NO_ID}},
      '{CMD_ADD,    8'h10, 13, 1'b1, '{ST_OK, NO_ID}},
      '{CMD_ADD,    8'h99, 1,  1'b1, '{ST_FULL, NO_ID}},
      '{CMD_SELECT, 8'h00, 3,  1'b0, '{ST_OK, NO_ID}},
      '{CMD_REMOVE, 8'h77, 1,  1'b1, '{ST_NOT_FOUND, NO_ID}},
      '{CMD_REMOVE, 8'h1C, 1,  1'b1, '{ST_OK, NO_ID}},
      '{CMD_REMOVE, 8'h55, 1,  1'b1, '{ST_OK, NO_ID}}
   };

   round_robin_ready_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_process_id (req_process_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_selected_id(rsp_selected_id)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic logic [3:0] slot_at(int offset);
      return q_head + 4'(offset);
   endfunction

   function automatic rsp_item_type predict_response(cmd_type cmd, logic [7:0] pid);
      rsp_item_type r;
      int           pos;
      r.status      = ST_OK;
      r.selected_id = NO_ID;
      pos           = -1;
      case (cmd)
         CMD_ADD: begin
            if (q_count >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               q_ids[slot_at(q_count)] = pid;
               q_count++;
            end
         end
         CMD_REMOVE: begin
            for (int i = 0; i < q_count; i++)
               if (pos < 0 && q_ids[slot_at(i)] == pid) pos = i;
            if (pos < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               for (int k = pos; k + 1 < q_count; k++)
                  q_ids[slot_at(k)] = q_ids[slot_at(k + 1)];
               q_count--;
               // the current entry always sits at the head
               if (pos == 0 || q_count == 0) q_current = 1'b0;
            end
         end
         CMD_SELECT: begin
            if (q_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               if (q_current && q_count > 1) begin
                  q_ids[slot_at(q_count)] = q_ids[q_head];
                  q_head++;
               end
               q_current     = 1'b1;
               r.selected_id = q_ids[q_head];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      if (errors < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
   endtask

   task automatic send_request(cmd_type cmd, logic [7:0] pid, bit fixed,
                               rsp_item_type fixed_rsp);
      int           gap;
      rsp_item_type predicted;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command    = cmd;
      req_process_id = pid;
      req_valid      = 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = predict_response(cmd, pid);
      n_cmd[cmd]++;
      n_status[predicted.status]++;
      pending_rsp.push_back(fixed ? fixed_rsp : predicted);
      @(negedge clock);
   endtask

   function automatic cmd_type pick_command(phase_kind_type kind);
      int w_add;
      int w_rem;
      int w_sel;
      int r;
      case (kind)
         PH_FILL:  begin w_add = 55; w_rem = 15; w_sel = 27; end
         PH_DRAIN: begin w_add = 15; w_rem = 55; w_sel = 27; end
         PH_CHURN: begin w_add = 20; w_rem = 20; w_sel = 57; end
         default:  begin w_add = 33; w_rem = 32; w_sel = 32; end
      endcase
      r = $urandom_range(0, 99);
      if (r < w_add) return CMD_ADD;
      if (r < w_add + w_rem) return CMD_REMOVE;
      if (r < w_add + w_rem + w_sel) return CMD_SELECT;
      return CMD_NONE;
   endfunction

   function automatic logic [7:0] pick_id(cmd_type cmd);
      int r;
      r = $urandom_range(0, 99);
      // removes mostly hit something queued
      if (cmd == CMD_REMOVE && q_count > 0 && r < 75)
         return q_ids[slot_at($urandom_range(0, q_count - 1))];
      if (r < 40) return 8'($urandom_range(0, 7));
      if (r < 48) return NO_ID;
      return 8'($urandom_range(0, 255));
   endfunction

   // result side: random hold-off ahead of each transfer, none in no-gap phases
   initial begin
      int n;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         n = no_gaps ? 0 : $urandom_range(0, 3);
         if (n > 0) begin
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch($sformatf("result %0h/%0h with nothing pending",
                                      rsp_status, rsp_selected_id));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status got %0d expected %0d",
                                         rsp_status, want.status));
            if (rsp_selected_id !== want.selected_id)
               report_mismatch($sformatf("selected_id got %0h expected %0h",
                                         rsp_selected_id, want.selected_id));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results pending",
                  idle_cycles, pending_rsp.size());
         $display("** round_robin_ready_queue: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      cmd_type        cmd;
      phase_kind_type kind;
      rsp_item_type   none_rsp;
      errors         = 0;
      no_gaps        = 1'b0;
      none_rsp       = '{ST_OK, NO_ID};
      q_head         = '0;
      q_count        = '0;
      q_current      = 1'b0;
      foreach (q_ids[i]) q_ids[i] = '0;
      foreach (n_cmd[i]) begin
         n_cmd[i]    = 0;
         n_status[i] = 0;
      end
      req_valid      = 1'b0;
      req_command    = CMD_NONE;
      req_process_id = '0;
      reset          = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[r])
         for (int n = 0; n < directed_rows[r].reps; n++)
            send_request(directed_rows[r].cmd, directed_rows[r].pid + 8'(n),
                         directed_rows[r].fixed, directed_rows[r].rsp);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         kind    = phase_kind_type'(ph % 4);
         no_gaps = (ph % 5 == 4);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            cmd = pick_command(kind);
            send_request(cmd, pick_id(cmd), 1'b0, none_rsp);
         end
      end
      no_gaps   = 1'b0;
      req_valid = 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d add, %0d remove, %0d select, %0d undefined requests",
               n_cmd[CMD_ADD], n_cmd[CMD_REMOVE], n_cmd[CMD_SELECT], n_cmd[CMD_NONE]);
      $display("statuses: %0d ok, %0d full, %0d not found, %0d empty; %0d mismatches",
               n_status[ST_OK], n_status[ST_FULL], n_status[ST_NOT_FOUND],
               n_status[ST_EMPTY], errors);
      if (errors == 0) begin
         $display("** round_robin_ready_queue: PASSED **");
      end else begin
         $display("** round_robin_ready_queue: FAILED **");
      end
      $finish;
   end

endmodule
